// ===== hdl/bwal_pkg.sv =====
`default_nettype none
// bwal_pkg: shared types, widths and constants of the windowed battery gauge
// no dependencies; used by every module of the block

package bwal_pkg;

  localparam int unsigned MAX_SAMPLES = 1023;

  localparam int unsigned MV_W   = 13;
  localparam int unsigned TS_W   = 32;
  localparam int unsigned WIN_W  = 16;
  localparam int unsigned LVL_W  = 7;
  localparam int unsigned CLS_W  = 3;
  localparam int unsigned ALR_W  = 2;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = MV_W + CNT_W;
  localparam int unsigned NUM_W  = SUM_W + LVL_W;
  localparam int unsigned DEN_W  = SUM_W;
  localparam int unsigned STEP_W = $clog2(NUM_W);

  // queue between front and back, power of two
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [LVL_W-1:0] LEVEL_MAX   = LVL_W'(100);
  localparam logic [LVL_W-1:0] LVL_CRIT_TH = LVL_W'(10);
  localparam logic [LVL_W-1:0] LVL_LOW_TH  = LVL_W'(25);
  localparam logic [LVL_W-1:0] LVL_MED_TH  = LVL_W'(50);
  localparam logic [LVL_W-1:0] LVL_HIGH_TH = LVL_W'(75);

  localparam logic [WIN_W-1:0] RST_WINDOW = WIN_W'(10000);
  localparam logic [MV_W-1:0]  RST_FLOOR  = MV_W'(100);
  localparam logic [MV_W-1:0]  RST_EMPTY  = MV_W'(3300);
  localparam logic [MV_W-1:0]  RST_FULL   = MV_W'(4200);

  typedef enum logic [CLS_W-1:0] {
    CLS_CRITICAL = 3'd0,
    CLS_LOW      = 3'd1,
    CLS_MEDIUM   = 3'd2,
    CLS_HIGH     = 3'd3,
    CLS_FULL     = 3'd4
  } class_t;

  typedef enum logic [ALR_W-1:0] {
    ALERT_NONE = 2'd0,
    ALERT_CRIT = 2'd1,
    ALERT_LOW  = 2'd2
  } alert_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_FLOOR  = 2'd1,
    CFG_EMPTY  = 2'd2,
    CFG_FULL   = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_DEN,
    ST_PCT,
    ST_DIV_AVG,
    ST_WAIT_AVG,
    ST_DIV_LVL,
    ST_WAIT_LVL,
    ST_FIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic [MV_W-1:0]  floor_mv;
    logic [MV_W-1:0]  empty_mv;
    logic [MV_W-1:0]  full_mv;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0] mv;
    logic [TS_W-1:0] now;
    logic            valid;
  } item_t;

  typedef struct packed {
    logic             ready_res;
    logic             updated;
    logic [MV_W-1:0]  average_mv;
    logic [LVL_W-1:0] level_pct;
    class_t           charge_class;
    alert_t           alert;
  } res_t;

  function automatic class_t class_of(input logic [LVL_W-1:0] lv);
    class_t c;
    priority if (lv <= LVL_CRIT_TH) c = CLS_CRITICAL;
    else if (lv <= LVL_LOW_TH)      c = CLS_LOW;
    else if (lv <= LVL_MED_TH)      c = CLS_MEDIUM;
    else if (lv <= LVL_HIGH_TH)     c = CLS_HIGH;
    else                            c = CLS_FULL;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bwal_front.sv =====
`default_nettype none
// bwal_front: input side, tags each item against the validity floor
// and holds it in a short queue for the back end; uses bwal_pkg

module bwal_front (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        push,
  output logic                       full,
  input  wire  [bwal_pkg::MV_W-1:0]  sample_mv,
  input  wire  [bwal_pkg::TS_W-1:0]  now_ms,
  input  wire  [bwal_pkg::MV_W-1:0]  floor_mv,
  input  wire                        q_pop,
  output logic                       q_empty,
  output bwal_pkg::item_t            q_item
);

  bwal_pkg::item_t                  mem_r [bwal_pkg::QDEPTH];
  logic [bwal_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [bwal_pkg::QCNT_W-1:0]      count_r;
  logic                             do_push, do_pop;
  bwal_pkg::item_t                  push_item;

  assign full    = (count_r == bwal_pkg::QCNT_W'(bwal_pkg::QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    push_item.mv    = sample_mv;
    push_item.now   = now_ms;
    push_item.valid = (sample_mv > floor_mv);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + bwal_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + bwal_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + bwal_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - bwal_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bwal_div.sv =====
`default_nettype none
// bwal_div: restoring divider, one quotient bit per cycle
// uses bwal_pkg widths; shared by the average and level paths

module bwal_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [bwal_pkg::NUM_W-1:0]  dividend,
  input  wire  [bwal_pkg::DEN_W-1:0]  divisor,
  output logic                        done,
  output logic [bwal_pkg::NUM_W-1:0]  quotient
);

  localparam int unsigned NW = bwal_pkg::NUM_W;
  localparam int unsigned DW = bwal_pkg::DEN_W;

  logic                             busy_r, done_r;
  logic [bwal_pkg::STEP_W-1:0]      step_r;
  logic [DW-1:0]                    rem_r, dsr_r;
  logic [NW-1:0]                    quo_r;
  logic [DW:0]                      rem_sh;
  logic [DW+1:0]                    diff;
  logic                             qbit;
  logic [DW-1:0]                    rem_nxt;

  assign rem_sh   = {rem_r, quo_r[NW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign qbit     = !diff[DW+1];
  assign rem_nxt  = qbit ? diff[DW-1:0] : rem_sh[DW-1:0];
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + bwal_pkg::STEP_W'(1);
        if (step_r == bwal_pkg::STEP_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NW-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bwal_back.sv =====
`default_nettype none
// bwal_back: window accumulator, level sequencer and result register
// uses bwal_pkg and bwal_div

module bwal_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bwal_pkg::cfg_t      cfg,
  input  wire                 q_empty,
  input  bwal_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                res_valid,
  output bwal_pkg::res_t      res,
  input  wire                 res_pop
);

  localparam int unsigned MV_W  = bwal_pkg::MV_W;
  localparam int unsigned SUM_W = bwal_pkg::SUM_W;
  localparam int unsigned CNT_W = bwal_pkg::CNT_W;
  localparam int unsigned NUM_W = bwal_pkg::NUM_W;
  localparam int unsigned LVL_W = bwal_pkg::LVL_W;
  localparam int unsigned TS_W  = bwal_pkg::TS_W;

  bwal_pkg::back_state_t state_r, state_nxt;

  // window state
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TS_W-1:0]     start_r;
  logic [MV_W-1:0]     avg_hold_r;
  logic [LVL_W-1:0]    level_hold_r;
  bwal_pkg::class_t    class_hold_r;
  logic                have_r;

  // per item work registers
  bwal_pkg::item_t     item_r;
  logic [TS_W-1:0]     elapsed_r;
  logic [SUM_W-1:0]    lo_r, hi_r, den_r;
  logic [NUM_W-1:0]    num_r;
  logic [MV_W-1:0]     avg_r;
  logic [LVL_W-1:0]    level_r;
  logic                need_div_r;
  logic                upd_r;

  // result register
  logic                res_valid_r;
  bwal_pkg::res_t      res_r;

  logic                close_win;
  logic [MV_W-1:0]     mul_a;
  logic [SUM_W-1:0]    mul_p;
  logic                div_start;
  logic [NUM_W-1:0]    div_dividend;
  logic [SUM_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_q;
  logic                res_load;
  logic                lvl_zero, lvl_full;
  bwal_pkg::alert_t    alert_now;

  bwal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign close_win = (elapsed_r >= TS_W'(cfg.window)) && (cnt_r != '0);
  assign mul_p     = {{(SUM_W-MV_W){1'b0}}, mul_a} * {{(SUM_W-CNT_W){1'b0}}, cnt_r};
  assign lvl_zero  = (sum_r <= lo_r);
  assign lvl_full  = (sum_r >= hi_r) || (cfg.full_mv <= cfg.empty_mv);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    alert_now = bwal_pkg::ALERT_NONE;
    if (have_r) begin
      if (class_hold_r == bwal_pkg::CLS_CRITICAL) begin
        alert_now = bwal_pkg::ALERT_CRIT;
      end else if (class_hold_r == bwal_pkg::CLS_LOW) begin
        alert_now = bwal_pkg::ALERT_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bwal_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    mul_a     = cfg.empty_mv;
    if (state_r == bwal_pkg::ST_DIV_LVL) begin
      div_dividend = num_r;
      div_divisor  = den_r;
    end else begin
      div_dividend = NUM_W'(sum_r);
      div_divisor  = SUM_W'(cnt_r);
    end
    unique case (state_r)
      bwal_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = bwal_pkg::ST_ACC;
        end
      end
      bwal_pkg::ST_ACC: begin
        state_nxt = bwal_pkg::ST_TEST;
      end
      bwal_pkg::ST_TEST: begin
        state_nxt = close_win ? bwal_pkg::ST_MUL_LO : bwal_pkg::ST_EMIT;
      end
      bwal_pkg::ST_MUL_LO: begin
        mul_a     = cfg.empty_mv;
        state_nxt = bwal_pkg::ST_MUL_HI;
      end
      bwal_pkg::ST_MUL_HI: begin
        mul_a     = cfg.full_mv;
        state_nxt = bwal_pkg::ST_MUL_DEN;
      end
      bwal_pkg::ST_MUL_DEN: begin
        mul_a     = cfg.full_mv - cfg.empty_mv;
        state_nxt = bwal_pkg::ST_PCT;
      end
      bwal_pkg::ST_PCT: begin
        state_nxt = bwal_pkg::ST_DIV_AVG;
      end
      bwal_pkg::ST_DIV_AVG: begin
        div_start = 1'b1;
        state_nxt = bwal_pkg::ST_WAIT_AVG;
      end
      bwal_pkg::ST_WAIT_AVG: begin
        if (div_done) begin
          state_nxt = need_div_r ? bwal_pkg::ST_DIV_LVL : bwal_pkg::ST_FIN;
        end
      end
      bwal_pkg::ST_DIV_LVL: begin
        div_start = 1'b1;
        state_nxt = bwal_pkg::ST_WAIT_LVL;
      end
      bwal_pkg::ST_WAIT_LVL: begin
        if (div_done) begin
          state_nxt = bwal_pkg::ST_FIN;
        end
      end
      bwal_pkg::ST_FIN: begin
        state_nxt = bwal_pkg::ST_EMIT;
      end
      bwal_pkg::ST_EMIT: begin
        if (!res_valid_r || res_pop) begin
          res_load  = 1'b1;
          state_nxt = bwal_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bwal_pkg::ST_IDLE;
      end
    endcase
  end

  // window state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      cnt_r        <= '0;
      start_r      <= '0;
      avg_hold_r   <= '0;
      level_hold_r <= '0;
      class_hold_r <= bwal_pkg::CLS_CRITICAL;
      have_r       <= 1'b0;
      upd_r        <= 1'b0;
    end else begin
      if (state_r == bwal_pkg::ST_ACC) begin
        upd_r <= 1'b0;
        if (item_r.valid && (cnt_r < CNT_W'(bwal_pkg::MAX_SAMPLES))) begin
          sum_r <= sum_r + SUM_W'(item_r.mv);
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (state_r == bwal_pkg::ST_FIN) begin
        avg_hold_r   <= avg_r;
        level_hold_r <= level_r;
        class_hold_r <= bwal_pkg::class_of(level_r);
        have_r       <= 1'b1;
        sum_r        <= '0;
        cnt_r        <= '0;
        start_r      <= item_r.now;
        upd_r        <= 1'b1;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == bwal_pkg::ST_ACC) begin
      elapsed_r <= item_r.now - start_r;
    end
    if (state_r == bwal_pkg::ST_MUL_LO) begin
      lo_r <= mul_p;
    end
    if (state_r == bwal_pkg::ST_MUL_HI) begin
      hi_r <= mul_p;
    end
    if (state_r == bwal_pkg::ST_MUL_DEN) begin
      den_r <= mul_p;
    end
    if (state_r == bwal_pkg::ST_PCT) begin
      num_r <= NUM_W'(sum_r - lo_r) * NUM_W'(bwal_pkg::LEVEL_MAX);
      priority if (lvl_zero) begin
        level_r    <= '0;
        need_div_r <= 1'b0;
      end else if (lvl_full) begin
        level_r    <= bwal_pkg::LEVEL_MAX;
        need_div_r <= 1'b0;
      end else begin
        level_r    <= '0;
        need_div_r <= 1'b1;
      end
    end
    if ((state_r == bwal_pkg::ST_WAIT_AVG) && div_done) begin
      avg_r <= (|div_q[NUM_W-1:MV_W]) ? '1 : div_q[MV_W-1:0];
    end
    if ((state_r == bwal_pkg::ST_WAIT_LVL) && div_done) begin
      level_r <= (div_q > NUM_W'(bwal_pkg::LEVEL_MAX)) ? bwal_pkg::LEVEL_MAX
                                                       : div_q[LVL_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (res_pop) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r.ready_res    <= have_r;
      res_r.updated      <= upd_r;
      res_r.average_mv   <= avg_hold_r;
      res_r.level_pct    <= level_hold_r;
      res_r.charge_class <= class_hold_r;
      res_r.alert        <= alert_now;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/battery_window_average_level.sv =====
`default_nettype none
// battery_window_average_level: top level of the windowed battery gauge
// holds the config registers; uses bwal_pkg, bwal_front, bwal_back
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in_     | to block  | in_push / in_full   | sample_mv, now_ms
//  out_    | from blk  | out_empty / out_pop | ready_res, updated, average_mv,
//          |           |                     | level_pct, charge_class, alert
//  cfg_    | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  an item that does not close a window passes these back end steps in order:
//  pop, accumulate, window test, emit
//  a closing item adds 3 multiply steps, 1 scale step, an average division
//  (start, 30 quotient bits, done), another division for the level when it
//  lies strictly between empty and full, and a step that updates the holds
//  a two item queue sits between front and back; the result register waits
//  for out_pop while new items still enter the queue
//  rst_n is synchronous; it clears the window, holds and config to defaults

module battery_window_average_level (
  input  wire                          clk,
  input  wire                          rst_n,
  // input items
  input  wire                          in_push,
  output logic                         in_full,
  input  wire  [bwal_pkg::MV_W-1:0]    in_sample_mv,
  input  wire  [bwal_pkg::TS_W-1:0]    in_now_ms,
  // result items
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic                         out_ready_res,
  output logic                         out_updated,
  output logic [bwal_pkg::MV_W-1:0]    out_average_mv,
  output logic [bwal_pkg::LVL_W-1:0]   out_level_pct,
  output logic [bwal_pkg::CLS_W-1:0]   out_charge_class,
  output logic [bwal_pkg::ALR_W-1:0]   out_alert,
  // config writes
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bwal_pkg::IDX_W-1:0]   cfg_index,
  input  wire  [bwal_pkg::CFG_W-1:0]   cfg_data
);

  bwal_pkg::cfg_t   cfg_r;
  logic             q_pop, q_empty;
  bwal_pkg::item_t  q_item;
  logic             res_valid;
  bwal_pkg::res_t   res;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window   <= bwal_pkg::RST_WINDOW;
      cfg_r.floor_mv <= bwal_pkg::RST_FLOOR;
      cfg_r.empty_mv <= bwal_pkg::RST_EMPTY;
      cfg_r.full_mv  <= bwal_pkg::RST_FULL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bwal_pkg::cfg_idx_t'(cfg_index))
        bwal_pkg::CFG_WINDOW: cfg_r.window   <= cfg_data[bwal_pkg::WIN_W-1:0];
        bwal_pkg::CFG_FLOOR:  cfg_r.floor_mv <= cfg_data[bwal_pkg::MV_W-1:0];
        bwal_pkg::CFG_EMPTY:  cfg_r.empty_mv <= cfg_data[bwal_pkg::MV_W-1:0];
        bwal_pkg::CFG_FULL:   cfg_r.full_mv  <= cfg_data[bwal_pkg::MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: floor check and item queue
  bwal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .sample_mv (in_sample_mv),
    .now_ms    (in_now_ms),
    .floor_mv  (cfg_r.floor_mv),
    .q_pop     (q_pop),
    .q_empty   (q_empty),
    .q_item    (q_item)
  );

  // back: window accumulation, average, level, class, result register
  bwal_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  assign out_empty        = !res_valid;
  assign out_ready_res    = res.ready_res;
  assign out_updated      = res.updated;
  assign out_average_mv   = res.average_mv;
  assign out_level_pct    = res.level_pct;
  assign out_charge_class = res.charge_class;
  assign out_alert        = res.alert;

endmodule

`default_nettype wire
